>>> hdl/btrr_pkg.sv
package btrr_pkg;

   localparam int MAX_WIDTH_DEF = 4096;

   localparam int PIX_W      = 8;
   localparam int COORD_W    = 16;
   localparam int LEN_W      = 13;
   localparam int BIDX_W     = 13;
   localparam int ROW_W      = 16;
   localparam int DIM_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // a byte closes at most four runs inside it plus one at the row end
   localparam int MAX_RUNS  = 5;
   localparam int RUN_CNT_W = 3;

   localparam int BIT_MASK   = 7;
   localparam int BYTE_SHIFT = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BITMAP_WIDTH  = 3'd0,
      CSR_BITMAP_HEIGHT = 3'd1,
      CSR_ROW_STRIDE    = 3'd2,
      CSR_X_OFFSET      = 3'd3,
      CSR_Y_OFFSET      = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [DIM_W-1:0]   bitmap_width;
      logic [ROW_W-1:0]   bitmap_height;
      logic [DIM_W-1:0]   row_stride;
      logic [COORD_W-1:0] x_offset;
      logic [COORD_W-1:0] y_offset;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] run_x;
      logic [COORD_W-1:0] run_y;
      logic [LEN_W-1:0]   run_length;
      logic               last_of_item;
   } run_type;

endpackage

>>> hdl/btrr_channels.sv
interface btrr_req_if import btrr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_byte;

   modport source (output valid, output pixel_byte, input ready);
   modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface btrr_rsp_if import btrr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] run_x;
   logic signed [COORD_W-1:0] run_y;
   logic [LEN_W-1:0]          run_length;
   logic                      last_of_item;

   modport source (output valid, output run_x, output run_y, output run_length,
                   output last_of_item, input ready);
   modport sink   (input valid, input run_x, input run_y, input run_length,
                   input last_of_item, output ready);
endinterface

interface btrr_csr_if import btrr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/btrr_scan.sv
module btrr_scan import btrr_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  cfg_type                  cfg,
   input  logic [PIX_W-1:0]         pixel_byte,
   input  logic [BIDX_W-1:0]        byte_index,
   input  logic [ROW_W-1:0]         row_count,
   input  logic                     run_open,
   input  logic [$clog2(MAX_WIDTH)-1:0] run_start,
   output logic [BIDX_W-1:0]        byte_index_nxt,
   output logic [ROW_W-1:0]         row_count_nxt,
   output logic                     run_open_nxt,
   output logic [$clog2(MAX_WIDTH)-1:0] run_start_nxt,
   output run_type                  runs [MAX_RUNS],
   output logic [RUN_CNT_W-1:0]     run_cnt
);

   localparam int SW = $clog2(MAX_WIDTH);
   localparam logic [15:0] MaxW = 16'(MAX_WIDTH);

   logic [15:0]        width;
   logic [DIM_W-1:0]   stride;
   logic [ROW_W-1:0]   height;
   logic [BIDX_W-1:0]  bidx;
   logic [15:0]        base;
   logic [15:0]        row_end;
   logic               row_last;
   logic [COORD_W-1:0] y_val;

   always_comb begin
      width  = ({3'b0, cfg.bitmap_width} > MaxW) ? MaxW : {3'b0, cfg.bitmap_width};
      stride = (cfg.row_stride == '0) ? DIM_W'(1) : cfg.row_stride;
      height = (cfg.bitmap_height == '0) ? ROW_W'(1) : cfg.bitmap_height;
      bidx   = (byte_index >= stride) ? '0 : byte_index;
      base   = 16'(bidx) << BYTE_SHIFT;
      row_end = ({3'b0, stride} << BYTE_SHIFT);
      if (row_end > width) begin
         row_end = width;
      end
      row_last = ({1'b0, bidx} + 14'd1) >= {1'b0, stride};
      y_val    = row_count + cfg.y_offset;
   end

   // walk the eight pixels, packing closed runs into the slots in order
   always_comb begin
      logic [15:0]          col;
      logic                 open;
      logic [SW-1:0]        start;
      logic [RUN_CNT_W-1:0] n;
      logic [15:0]          len;

      open = run_open;
      start = run_start;
      n = '0;
      col = '0;
      len = '0;
      for (int i = 0; i < MAX_RUNS; i++) begin
         runs[i] = '0;
      end
      for (int b = 0; b <= BIT_MASK; b++) begin
         col = base + 16'(b);
         if (col < width) begin
            if (pixel_byte[b] && !open) begin
               open = 1'b1;
               start = col[SW-1:0];
            end else if (!pixel_byte[b] && open) begin
               len = col - 16'(start);
               runs[n].run_x = 16'(start) + cfg.x_offset;
               runs[n].run_y = y_val;
               runs[n].run_length = len[LEN_W-1:0];
               runs[n].last_of_item = 1'b0;
               n = n + 1'b1;
               open = 1'b0;
            end
         end
      end
      if (row_last && open) begin
         len = row_end - 16'(start);
         runs[n].run_x = 16'(start) + cfg.x_offset;
         runs[n].run_y = y_val;
         runs[n].run_length = len[LEN_W-1:0];
         runs[n].last_of_item = 1'b0;
         n = n + 1'b1;
         open = 1'b0;
      end
      if (n != '0) begin
         runs[n - 1'b1].last_of_item = 1'b1;
      end
      run_cnt = n;
      run_open_nxt = open;
      run_start_nxt = start;
   end

   always_comb begin
      if (row_last) begin
         byte_index_nxt = '0;
         if ({1'b0, row_count} + 17'd1 >= {1'b0, height}) begin
            row_count_nxt = '0;
         end else begin
            row_count_nxt = row_count + 1'b1;
         end
      end else begin
         byte_index_nxt = bidx + 1'b1;
         row_count_nxt = row_count;
      end
   end

endmodule

>>> hdl/bitmap_to_row_runs.sv
// an accepted byte waits in the input register until the result buffer drains; its
//   runs are then scanned into the buffer, whose head slot drives the response
// throughput: one byte per cycle while each byte closes at most one run and rsp_ch
//   is ready; a byte closing more holds the buffer, emitting one run per ready cycle
// reset: synchronous, active high; clears the row/column counters and the open run,
//   empties the pipeline and loads width 1, height 1, stride 1, offsets 0
module bitmap_to_row_runs import btrr_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   btrr_req_if.sink    req_ch,
   btrr_rsp_if.source  rsp_ch,
   btrr_csr_if.sink    csr_ch
);

   localparam int SW = $clog2(MAX_WIDTH);

   cfg_type              cfg_ff;
   logic                 a_vld_ff;
   logic [PIX_W-1:0]     a_byte_ff;
   run_type              buf_ff [MAX_RUNS];
   logic [RUN_CNT_W-1:0] b_left_ff;
   logic [BIDX_W-1:0]    byte_index_ff;
   logic [ROW_W-1:0]     row_count_ff;
   logic                 run_open_ff;
   logic [SW-1:0]        run_start_ff;

   logic [BIDX_W-1:0]    byte_index_in;
   logic [ROW_W-1:0]     row_count_in;
   logic                 run_open_in;
   logic [SW-1:0]        run_start_in;
   run_type              scan_runs [MAX_RUNS];
   logic [RUN_CNT_W-1:0] scan_cnt;

   logic drain_done;
   logic a_adv;
   logic req_fire;
   logic rsp_pop;

   assign rsp_pop    = rsp_ch.valid && rsp_ch.ready;
   assign drain_done = (b_left_ff == '0) || (b_left_ff == RUN_CNT_W'(1) && rsp_ch.ready);
   assign a_adv      = a_vld_ff && drain_done;
   assign req_ch.ready = !reset && (!a_vld_ff || a_adv);
   assign req_fire   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = !reset;

   assign rsp_ch.valid        = (b_left_ff != '0);
   assign rsp_ch.run_x        = buf_ff[0].run_x;
   assign rsp_ch.run_y        = buf_ff[0].run_y;
   assign rsp_ch.run_length   = buf_ff[0].run_length;
   assign rsp_ch.last_of_item = buf_ff[0].last_of_item;

   btrr_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
      .cfg            (cfg_ff),
      .pixel_byte     (a_byte_ff),
      .byte_index     (byte_index_ff),
      .row_count      (row_count_ff),
      .run_open       (run_open_ff),
      .run_start      (run_start_ff),
      .byte_index_nxt (byte_index_in),
      .row_count_nxt  (row_count_in),
      .run_open_nxt   (run_open_in),
      .run_start_nxt  (run_start_in),
      .runs           (scan_runs),
      .run_cnt        (scan_cnt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bitmap_width  <= DIM_W'(1);
         cfg_ff.bitmap_height <= ROW_W'(1);
         cfg_ff.row_stride    <= DIM_W'(1);
         cfg_ff.x_offset      <= '0;
         cfg_ff.y_offset      <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_BITMAP_WIDTH:  cfg_ff.bitmap_width  <= csr_ch.data[DIM_W-1:0];
            CSR_BITMAP_HEIGHT: cfg_ff.bitmap_height <= csr_ch.data[ROW_W-1:0];
            CSR_ROW_STRIDE:    cfg_ff.row_stride    <= csr_ch.data[DIM_W-1:0];
            CSR_X_OFFSET:      cfg_ff.x_offset      <= csr_ch.data[COORD_W-1:0];
            CSR_Y_OFFSET:      cfg_ff.y_offset      <= csr_ch.data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (req_fire) begin
         a_vld_ff <= 1'b1;
      end else if (a_adv) begin
         a_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_byte_ff <= req_ch.pixel_byte;
      end
   end

   // scan state advances once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         row_count_ff  <= '0;
         run_open_ff   <= 1'b0;
         run_start_ff  <= '0;
      end else if (a_adv) begin
         byte_index_ff <= byte_index_in;
         row_count_ff  <= row_count_in;
         run_open_ff   <= run_open_in;
         run_start_ff  <= run_start_in;
      end
   end

   // result buffer, head slot drives the response
   always_ff @(posedge clock) begin
      if (reset) begin
         b_left_ff <= '0;
      end else if (a_adv) begin
         b_left_ff <= scan_cnt;
      end else if (rsp_pop) begin
         b_left_ff <= b_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         buf_ff <= scan_runs;
      end else if (rsp_pop) begin
         for (int i = 0; i < MAX_RUNS - 1; i++) begin
            buf_ff[i] <= buf_ff[i + 1];
         end
      end
   end

endmodule

>>> hdl/btrr_checker.sv
module btrr_checker import btrr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] run_x,
   input logic [COORD_W-1:0] run_y,
   input logic [LEN_W-1:0]   run_length,
   input logic               last_of_item
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // the remaining runs of one byte follow without a gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_of_item |=> rsp_valid)
      else $error("gap inside the runs of one byte");

   // with no run waiting the block always takes a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // a stalled request always has a run waiting ahead of it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("request stalled with no run waiting");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(run_x) && $stable(run_y)
         && $stable(run_length) && $stable(last_of_item))
      else $error("stalled response changed");

endmodule

bind bitmap_to_row_runs btrr_checker u_btrr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .run_x        (rsp_ch.run_x),
   .run_y        (rsp_ch.run_y),
   .run_length   (rsp_ch.run_length),
   .last_of_item (rsp_ch.last_of_item)
);

>>> tb/bitmap_to_row_runs_tb.sv
module bitmap_to_row_runs_tb import btrr_pkg::*; ();

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 16;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_REPORTS   = 10;

   // index past the register list, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_NO_RUN,
      CHK_ONE_RUN
   } step_check_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [PIX_W-1:0]      pix;
      step_check_type        check;
      run_type               typed_run;
   } step_type;

   logic clock = 1'b0;
   logic reset;

   btrr_req_if req_ch ();
   btrr_rsp_if rsp_ch ();
   btrr_csr_if csr_ch ();

   bitmap_to_row_runs u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // shadow of the block: registers and row scan state
   cfg_type   live_cfg;
   int        col_byte;
   int        cur_row;
   bit        run_active;
   int        run_begin;

   run_type   pending_runs[$];
   run_type   new_runs[$];
   step_type  directed_steps[$];
   int        bad_runs = 0;
   int        burst_left = 0;
   bit        hold_wanted = 1'b0;
   bit        hold_done = 1'b0;

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_BITMAP_WIDTH:  live_cfg.bitmap_width  = value[DIM_W-1:0];
         CSR_BITMAP_HEIGHT: live_cfg.bitmap_height = value[ROW_W-1:0];
         CSR_ROW_STRIDE:    live_cfg.row_stride    = value[DIM_W-1:0];
         CSR_X_OFFSET:      live_cfg.x_offset      = value[COORD_W-1:0];
         CSR_Y_OFFSET:      live_cfg.y_offset      = value[COORD_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic run_type close_run(input int end_col);
      run_type r;
      r.run_x        = COORD_W'(run_begin + int'(live_cfg.x_offset));
      r.run_y        = COORD_W'(cur_row + int'(live_cfg.y_offset));
      r.run_length   = LEN_W'(end_col - run_begin);
      r.last_of_item = 1'b0;
      return r;
   endfunction

   // scans one byte of the row and leaves the runs it closes in new_runs
   function automatic void extract_runs(input logic [PIX_W-1:0] pix);
      int width;
      int stride;
      int height;
      int base;
      int col;
      int end_col;
      width  = (int'(live_cfg.bitmap_width) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF
                                                              : int'(live_cfg.bitmap_width);
      stride = (live_cfg.row_stride == '0) ? 1 : int'(live_cfg.row_stride);
      height = (live_cfg.bitmap_height == '0) ? 1 : int'(live_cfg.bitmap_height);
      new_runs.delete();
      if (col_byte >= stride)
         col_byte = 0;
      base = col_byte << BYTE_SHIFT;
      for (int b = 0; b <= BIT_MASK; b++) begin
         col = base + b;
         if (col < width) begin
            if (pix[b] && !run_active) begin
               run_active = 1'b1;
               run_begin  = col;
            end else if (!pix[b] && run_active) begin
               new_runs.insert(new_runs.size(), close_run(col));
               run_active = 1'b0;
            end
         end
      end
      if (col_byte + 1 >= stride) begin
         if (run_active) begin
            end_col = stride << BYTE_SHIFT;
            if (end_col > width)
               end_col = width;
            new_runs.insert(new_runs.size(), close_run(end_col));
            run_active = 1'b0;
         end
         col_byte = 0;
         cur_row  = (cur_row + 1 >= height) ? 0 : cur_row + 1;
      end else begin
         col_byte++;
      end
      if (new_runs.size() > 0)
         new_runs[new_runs.size() - 1].last_of_item = 1'b1;
   endfunction

   function automatic void check_run();
      run_type want;
      if (pending_runs.size() == 0) begin
         bad_runs++;
         if (bad_runs <= MAX_REPORTS)
            $display("unexpected run: x=%h y=%h len=%0d last=%b",
                     rsp_ch.run_x, rsp_ch.run_y, rsp_ch.run_length, rsp_ch.last_of_item);
      end else begin
         want = pending_runs.pop_front();
         if (rsp_ch.run_x !== want.run_x || rsp_ch.run_y !== want.run_y ||
             rsp_ch.run_length !== want.run_length ||
             rsp_ch.last_of_item !== want.last_of_item) begin
            bad_runs++;
            if (bad_runs <= MAX_REPORTS)
               $display({"run mismatch: expected x=%h y=%h len=%0d last=%b,",
                         " got x=%h y=%h len=%0d last=%b"},
                        want.run_x, want.run_y, want.run_length, want.last_of_item,
                        rsp_ch.run_x, rsp_ch.run_y, rsp_ch.run_length, rsp_ch.last_of_item);
         end
      end
   endfunction

   task automatic tbl_csr(input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] value);
      step_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.idx    = idx;
      s.data   = value;
      s.check  = CHK_NO_RUN;
      directed_steps.insert(directed_steps.size(), s);
   endtask

   task automatic tbl_pix(input logic [PIX_W-1:0] pix, input step_check_type check,
                          input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                          input logic [LEN_W-1:0] len);
      step_type s;
      s = '0;
      s.pix                    = pix;
      s.check                  = check;
      s.typed_run.run_x        = x;
      s.typed_run.run_y        = y;
      s.typed_run.run_length   = len;
      s.typed_run.last_of_item = 1'b1;
      directed_steps.insert(directed_steps.size(), s);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      apply_csr(idx, value);
   endtask

   task automatic send_byte(input logic [PIX_W-1:0] pix, input step_check_type check,
                            input run_type typed_run);
      csr_ch.valid       <= 1'b0;
      req_ch.valid       <= 1'b1;
      req_ch.pixel_byte  <= pix;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      extract_runs(pix);
      case (check)
         CHK_PREDICT: foreach (new_runs[i]) pending_runs.insert(pending_runs.size(), new_runs[i]);
         CHK_ONE_RUN: pending_runs.insert(pending_runs.size(), typed_run);
         default: ;
      endcase
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // sender pauses until every run is back and the pipeline is empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_runs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: randomly chosen stall patterns, one long hold-off on request
   initial begin
      ready_mode_type mode;
      int             hold_cnt;
      bit             nxt;
      mode = READY_ALWAYS;
      hold_cnt = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            check_run();
         if (cycle_count % 64 == 0)
            mode = ready_mode_type'($urandom_range(0, 3));
         if (hold_cnt > 0) begin
            hold_cnt--;
            nxt = 1'b0;
         end else if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt  = LONG_HOLD;
            nxt       = 1'b0;
         end else begin
            case (mode)
               READY_ALWAYS: nxt = 1'b1;
               READY_COIN:   nxt = 1'($urandom_range(0, 1));
               READY_SPARSE: nxt = ($urandom_range(0, 3) == 0);
               default:      nxt = (cycle_count % 3 != 0);
            endcase
         end
         rsp_ch.ready <= nxt;
      end
   end

   initial begin
      bit              prev_csr;
      logic [PIX_W-1:0] pix;
      logic [CSR_DATA_W-1:0] value;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.pixel_byte = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_BITMAP_WIDTH;
      csr_ch.data       = '0;

      live_cfg.bitmap_width  = DIM_W'(1);
      live_cfg.bitmap_height = ROW_W'(1);
      live_cfg.row_stride    = DIM_W'(1);
      live_cfg.x_offset      = '0;
      live_cfg.y_offset      = '0;
      col_byte   = 0;
      cur_row    = 0;
      run_active = 1'b0;
      run_begin  = 0;

      // reset values: one pixel wide, one byte per row
      tbl_pix(8'h01, CHK_ONE_RUN, 16'h0000, 16'h0000, 13'd1);
      tbl_pix(8'hFE, CHK_NO_RUN, '0, '0, '0);
      // zero height acts as one row
      tbl_csr(CSR_BITMAP_WIDTH, 16'd8);
      tbl_csr(CSR_BITMAP_HEIGHT, 16'd0);
      tbl_pix(8'hFF, CHK_ONE_RUN, 16'h0000, 16'h0000, 13'd8);
      tbl_pix(8'h55, CHK_PREDICT, '0, '0, '0);
      // run carried across bytes, then a byte that closes five runs; offsets wrap
      tbl_csr(CSR_X_OFFSET, 16'h8000);
      tbl_csr(CSR_Y_OFFSET, 16'h7FFF);
      tbl_csr(CSR_BITMAP_WIDTH, 16'd16);
      tbl_csr(CSR_ROW_STRIDE, 16'd2);
      tbl_csr(CSR_BITMAP_HEIGHT, 16'd2);
      tbl_pix(8'h80, CHK_PREDICT, '0, '0, '0);
      tbl_pix(8'hAA, CHK_PREDICT, '0, '0, '0);
      tbl_pix(8'hFF, CHK_NO_RUN, '0, '0, '0);
      tbl_pix(8'h00, CHK_ONE_RUN, 16'h8000, 16'h8000, 13'd8);
      // width past the maximum (upper data bits dropped), zero stride
      tbl_csr(CSR_X_OFFSET, 16'h7FFF);
      tbl_csr(CSR_Y_OFFSET, 16'h8000);
      tbl_csr(CSR_BITMAP_WIDTH, 16'hFFFF);
      tbl_csr(CSR_ROW_STRIDE, 16'd0);
      tbl_pix(8'h81, CHK_PREDICT, '0, '0, '0);
      // zero width never yields a run
      tbl_csr(CSR_BITMAP_WIDTH, 16'd0);
      tbl_pix(8'hFF, CHK_NO_RUN, '0, '0, '0);
      // padding byte past the width closes the run at the width
      tbl_csr(CSR_BITMAP_WIDTH, 16'd12);
      tbl_csr(CSR_ROW_STRIDE, 16'd3);
      tbl_csr(CSR_BITMAP_HEIGHT, 16'd1);
      tbl_csr(CSR_X_OFFSET, 16'd0);
      tbl_csr(CSR_Y_OFFSET, 16'd0);
      tbl_pix(8'hF0, CHK_NO_RUN, '0, '0, '0);
      tbl_pix(8'hFF, CHK_NO_RUN, '0, '0, '0);
      tbl_pix(8'hFF, CHK_ONE_RUN, 16'd4, 16'd0, 13'd8);
      // stride shorter than the width closes at eight times the stride
      tbl_csr(CSR_BITMAP_WIDTH, 16'd40);
      tbl_csr(CSR_ROW_STRIDE, 16'd2);
      tbl_pix(8'h00, CHK_NO_RUN, '0, '0, '0);
      tbl_pix(8'hC0, CHK_ONE_RUN, 16'd14, 16'd0, 13'd2);
      tbl_csr(CSR_SPARE_IDX, 16'hFFFF);
      tbl_pix(8'h01, CHK_ONE_RUN, 16'd0, 16'd0, 13'd1);
      tbl_pix(8'h00, CHK_NO_RUN, '0, '0, '0);
      // largest sizes, then a stride change in the middle of a row
      tbl_csr(CSR_BITMAP_WIDTH, 16'd4096);
      tbl_csr(CSR_ROW_STRIDE, 16'h1FFF);
      tbl_csr(CSR_BITMAP_HEIGHT, 16'hFFFF);
      tbl_pix(8'hFF, CHK_PREDICT, '0, '0, '0);
      tbl_pix(8'h3C, CHK_PREDICT, '0, '0, '0);
      tbl_csr(CSR_ROW_STRIDE, 16'd1);
      tbl_pix(8'h81, CHK_PREDICT, '0, '0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      prev_csr = 1'b0;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_csr) begin
            if (!prev_csr)
               settle();
            write_csr(directed_steps[i].idx, directed_steps[i].data);
         end else begin
            send_byte(directed_steps[i].pix, directed_steps[i].check,
                      directed_steps[i].typed_run);
         end
         prev_csr = directed_steps[i].is_csr;
      end

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         if (ph == 2)
            hold_wanted = 1'b1;
         case ($urandom_range(0, 9))
            0:       value = 16'd0;
            1:       value = 16'd4096;
            2:       value = 16'($urandom_range(4097, 8191));
            3:       value = 16'($urandom);
            default: value = 16'($urandom_range(1, 40));
         endcase
         // the long hold-off needs bytes that yield runs
         if (ph == 2)
            value = 16'($urandom_range(8, 40));
         write_csr(CSR_BITMAP_WIDTH, value);
         value = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         write_csr(CSR_ROW_STRIDE, value);
         case ($urandom_range(0, 5))
            0:       value = 16'd0;
            1:       value = 16'hFFFF;
            default: value = 16'($urandom_range(1, 4));
         endcase
         write_csr(CSR_BITMAP_HEIGHT, value);
         case ($urandom_range(0, 4))
            0:       value = 16'h8000;
            1:       value = 16'h7FFF;
            2:       value = 16'h0000;
            default: value = 16'($urandom);
         endcase
         write_csr(CSR_X_OFFSET, value);
         case ($urandom_range(0, 4))
            0:       value = 16'h8000;
            1:       value = 16'h7FFF;
            2:       value = 16'h0000;
            default: value = 16'($urandom);
         endcase
         write_csr(CSR_Y_OFFSET, value);
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_SPARE_IDX, 16'($urandom));
         for (int k = 0; k < 15; k++) begin
            case ($urandom_range(0, 5))
               0:       pix = 8'hFF;
               1:       pix = 8'h00;
               2:       pix = ($urandom_range(0, 1) != 0) ? 8'h55 : 8'hAA;
               default: pix = 8'($urandom);
            endcase
            send_byte(pix, CHK_PREDICT, '0);
         end
      end

      // a row of set pixels, one long run closed at the row end
      settle();
      write_csr(CSR_BITMAP_WIDTH, 16'd4096);
      write_csr(CSR_ROW_STRIDE, 16'd16);
      write_csr(CSR_BITMAP_HEIGHT, 16'd1);
      write_csr(CSR_X_OFFSET, 16'($urandom));
      write_csr(CSR_Y_OFFSET, 16'($urandom));
      repeat (16) send_byte(8'hFF, CHK_PREDICT, '0);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_runs == 0 && pending_runs.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
